// File: src/l3ph_pkg.sv
// Shared types, command codes and lookup3 round functions for the pair hash engine.
// Used by every module of the block; depends on nothing.
package l3ph_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_CONT    = 2'd1;
  localparam logic [1:0] CMD_RESTORE = 2'd2;

  // How the back end picks the base state of a block.
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_CONT    = 2'd1;
  localparam logic [1:0] MODE_RESTORE = 2'd2;

  localparam logic [31:0] SEED_BASE = 32'hdeadbeef;

  // Last round index of the mix and of the final.
  localparam logic [2:0] STEP_MIX_END   = 3'd5;
  localparam logic [2:0] STEP_FINAL_END = 3'd6;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } abc_t;

  // One classified block as it sits in the queue.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] seed;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic        last;
    logic        save;
  } job_t;

  // Status of the back end, seen by the top level.
  typedef struct packed {
    logic       busy;
    logic       last;
    logic [2:0] step;
  } back_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
    return (v << r) | (v >> (6'd32 - {1'b0, r}));
  endfunction

  // One round of the six-round mix.
  function automatic abc_t mix_step(input logic [2:0] step, input abc_t s);
    abc_t t;
    t = s;
    case (step)
      3'd0: begin t.a = (s.a - s.c) ^ rotl32(s.c, 5'd4);  t.c = s.c + s.b; end
      3'd1: begin t.b = (s.b - s.a) ^ rotl32(s.a, 5'd6);  t.a = s.a + s.c; end
      3'd2: begin t.c = (s.c - s.b) ^ rotl32(s.b, 5'd8);  t.b = s.b + s.a; end
      3'd3: begin t.a = (s.a - s.c) ^ rotl32(s.c, 5'd16); t.c = s.c + s.b; end
      3'd4: begin t.b = (s.b - s.a) ^ rotl32(s.a, 5'd19); t.a = s.a + s.c; end
      default: begin t.c = (s.c - s.b) ^ rotl32(s.b, 5'd4); t.b = s.b + s.a; end
    endcase
    return t;
  endfunction

  // One round of the seven-round final.
  function automatic abc_t final_step(input logic [2:0] step, input abc_t s);
    abc_t t;
    t = s;
    case (step)
      3'd0: t.c = (s.c ^ s.b) - rotl32(s.b, 5'd14);
      3'd1: t.a = (s.a ^ s.c) - rotl32(s.c, 5'd11);
      3'd2: t.b = (s.b ^ s.a) - rotl32(s.a, 5'd25);
      3'd3: t.c = (s.c ^ s.b) - rotl32(s.b, 5'd16);
      3'd4: t.a = (s.a ^ s.c) - rotl32(s.c, 5'd4);
      3'd5: t.b = (s.b ^ s.a) - rotl32(s.a, 5'd14);
      default: t.c = (s.c ^ s.b) - rotl32(s.b, 5'd24);
    endcase
    return t;
  endfunction

endpackage

// File: src/l3ph_if.sv
// Valid/ready channel interfaces for key blocks in and hash values out.
// Depends on nothing.
interface l3ph_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] word_lo;
  logic [31:0] word_mid;
  logic [31:0] word_hi;
  logic [31:0] total_length;
  logic        is_last;
  logic        save_prefix;

  modport source (output valid, cmd, word_lo, word_mid, word_hi, total_length, is_last,
                  save_prefix, input ready);
  modport sink (input valid, cmd, word_lo, word_mid, word_hi, total_length, is_last,
                save_prefix, output ready);
endinterface

interface l3ph_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

// File: src/lookup3_pair_hash_engine.sv
// Top level of the lookup3 pair hash engine: front end, block queue and back end.
// Depends on l3ph_pkg, l3ph_if, l3ph_front, l3ph_queue and l3ph_back.
//
// The key arrives on key_in as 12-byte blocks of three little-endian words. Each
// block carries a command: start seeds a, b and c from the total length, continue
// resumes the running state, restore resumes the saved prefix midstate. A short
// tail block must be zero padded by the sender. A non-last block gets the six-round
// mix and may save the resulting state as the prefix midstate; a last block gets
// the seven-round final and produces one item on hash_out, final c over final b.
// A block accepted into an empty engine is written into the queue, then popped into
// the back end's a, b, c registers; a last block's hash is loaded into the result
// register when its final round completes. The back end runs one round per cycle
// on a single a, b, c register set, except while a stall on hash_out holds a final
// round, and loads the next block in the same cycle as the previous one's final
// round. A two-entry queue keeps key_in ready while the back end is working, until
// it holds two blocks. When hash_out stalls, the result register holds its item;
// a following last block waits in its final round until the register frees, and
// key_in drops ready once the queue is full. Reset clears the running and saved
// states to zero, empties the queue and drops hash_out.valid.
module lookup3_pair_hash_engine import l3ph_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  l3ph_in_if.sink     key_in,
  l3ph_out_if.source  hash_out
);

  logic         fr_valid;
  logic         fr_ready;
  job_t         fr_job;
  logic         q_valid;
  logic         q_ready;
  job_t         q_job;
  back_status_t back_st;

  l3ph_front u_front (
    .key_in    (key_in),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  l3ph_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_job)
  );

  l3ph_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .hash_out  (hash_out),
    .status    (back_st)
  );

  // A mix block never runs past its last round.
  a_mix_step_range: assert property (@(posedge clk) disable iff (rst)
    (back_st.busy && !back_st.last) |-> (back_st.step <= STEP_MIX_END))
    else $error("mix round counter out of range");

  // The back end takes a new block only when idle or finishing the current one.
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && back_st.busy) |->
      (back_st.step == (back_st.last ? STEP_FINAL_END : STEP_MIX_END)))
    else $error("block loaded while the back end is mid-run");

  // A result appears only after a final round.
  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_out.valid) |-> $past(back_st.busy && back_st.last))
    else $error("hash produced without a final");

  // Reset empties the result register.
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !hash_out.valid)
    else $error("result valid after reset");

endmodule

// File: src/l3ph_front.sv
// Front end: accepts key blocks, decodes the command and precomputes the start seed.
// Depends on l3ph_pkg and l3ph_in_if.
module l3ph_front import l3ph_pkg::*; (
  l3ph_in_if.sink    key_in,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  logic [1:0] mode;

  // Unused command code behaves as continue.
  always_comb begin
    unique case (key_in.cmd)
      CMD_START:   mode = MODE_START;
      CMD_RESTORE: mode = MODE_RESTORE;
      default:     mode = MODE_CONT;
    endcase
  end

  // The item goes straight into the queue when it has room.
  assign key_in.ready = job_ready;
  assign job_valid    = key_in.valid;

  always_comb begin
    job.mode = mode;
    job.seed = SEED_BASE + key_in.total_length;
    job.w0   = key_in.word_lo;
    job.w1   = key_in.word_mid;
    job.w2   = key_in.word_hi;
    job.last = key_in.is_last;
    job.save = key_in.save_prefix & ~key_in.is_last;
  end

endmodule

// File: src/l3ph_queue.sv
// Two-entry queue of classified blocks between the front and back ends.
// Depends on l3ph_pkg.
module l3ph_queue import l3ph_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: src/l3ph_back.sv
// Back end: one lookup3 mix or final round per cycle unless hash_out stalls; keeps the
// running and saved states and the result register. Depends on l3ph_pkg, l3ph_out_if.
module l3ph_back import l3ph_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  job_t          job,
  l3ph_out_if.source    hash_out,
  output back_status_t  status
);

  abc_t       cur;
  abc_t       saved;
  abc_t       rnd;
  abc_t       post;
  abc_t       saved_post;
  abc_t       base;
  abc_t       load;
  logic       busy;
  logic       last;
  logic       save;
  logic [2:0] step;
  logic       done;
  logic       stall;
  logic       pop;

  // One round on the current state.
  always_comb begin
    if (last) begin
      rnd = final_step(step, cur);
    end else begin
      rnd = mix_step(step, cur);
    end
  end

  assign done  = busy && (step == (last ? STEP_FINAL_END : STEP_MIX_END));
  assign stall = done && last && hash_out.valid && !hash_out.ready;

  // Running and saved state as they stand once this cycle's round commits.
  assign post       = done ? rnd : cur;
  assign saved_post = (done && save) ? rnd : saved;

  assign job_ready = !busy || (done && !stall);
  assign pop       = job_valid && job_ready;

  // Base state of the next block, plus its key words.
  always_comb begin
    unique case (job.mode)
      MODE_START:   base = '{a: job.seed, b: job.seed, c: job.seed};
      MODE_RESTORE: base = saved_post;
      default:      base = post;
    endcase
    load.a = base.a + job.w0;
    load.b = base.b + job.w1;
    load.c = base.c + job.w2;
  end

  // Round sequencer and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= '0;
      saved <= '0;
      busy  <= 1'b0;
      step  <= 3'd0;
      last  <= 1'b0;
      save  <= 1'b0;
    end else begin
      if (!stall) begin
        saved <= saved_post;
      end
      if (pop) begin
        cur  <= load;
        busy <= 1'b1;
        step <= 3'd0;
        last <= job.last;
        save <= job.save;
      end else if (busy && !stall) begin
        cur <= rnd;
        if (done) begin
          busy <= 1'b0;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  // Result register: loads when a final completes, clears when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_out.valid <= 1'b0;
    end else if (done && last && !stall) begin
      hash_out.valid <= 1'b1;
    end else if (hash_out.ready) begin
      hash_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && last && !stall) begin
      hash_out.hash_value <= {rnd.c, rnd.b};
    end
  end

  assign status = '{busy: busy, last: last, step: step};

endmodule
